[hdl/swfrm_pkg.sv]
// package for the sliding window frame rate meter
// field widths, register indexes, reset values and the sequencer state type
package swfrm_pkg;

  localparam int TICK_W = 32;
  localparam int FREQ_W = 32;
  localparam int PERIOD_W = 16;
  localparam int RATE_W = 32;
  localparam int FRAC_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WINDOW_DEFAULT = 100;

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000000);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(60);

  localparam logic [CFG_IDX_W-1:0] REG_TICK_FREQUENCY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

[hdl/swfrm_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module swfrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/swfrm_mul.sv]
// bit serial shift-add multiplier, one multiplier bit per cycle, msb first
// no dependencies
module swfrm_mul #(
  parameter int A_W = 7,
  parameter int B_W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int P_W = A_W + B_W;
  localparam int CNT_W = $clog2(A_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   mplr;
  logic [B_W-1:0]   mcand;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(A_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mplr <= a;
      mcand <= b;
      product <= '0;
    end else if (busy) begin
      product <= {product[P_W-2:0], 1'b0} + (mplr[A_W-1] ? P_W'(mcand) : P_W'(0));
      mplr <= {mplr[A_W-2:0], 1'b0};
    end
  end

endmodule

[hdl/swfrm_div.sv]
// bit serial restoring divider, one quotient bit per cycle
// keeps the low quotient bits and flags any bit lost above them
module swfrm_div #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 39,
  parameter int Q_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot,
  output logic             ovf
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_reg;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign diff = {1'b0, trial} - {2'b00, den_reg};
  assign ge = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_reg <= den;
      rem <= '0;
      quot <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[Q_W-2:0], ge};
      ovf <= ovf | quot[Q_W-1];
    end
  end

endmodule

[hdl/sliding_window_frame_rate_meter.sv]
// sliding window frame rate meter: rate = count * tick_frequency * 256 / window sum
// result path: an accepted input word passes the states sub, add, mul, div and out in order,
// with the serial multiplier running in mul and the bit serial divider running in div
// one word at a time: the next input word is taken from the cycle after the result is
// loaded, and the result load waits while a held result word has not been taken
// synchronous reset; ring entries not yet written read as zero via the fill count
module sliding_window_frame_rate_meter
  import swfrm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TICK_W-1:0]     frame_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RATE_W-1:0]     rate_q8,
  output logic                  rate_updated
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W = TICK_W + CNT_W;
  localparam int PROD_W = CNT_W + FREQ_W;
  localparam int NUM_W = PROD_W + FRAC_W;

  state_t state, state_next;

  logic [FREQ_W-1:0]   tick_frequency;
  logic [PERIOD_W-1:0] update_period;
  logic [SUM_W-1:0]    window_sum;
  logic [SLOT_W-1:0]   write_slot;
  logic [CNT_W-1:0]    filled_count;
  logic [PERIOD_W-1:0] frames_since_update;
  logic [TICK_W-1:0]   ticks;
  logic                flag;

  logic                accept;
  logic                mul_start;
  logic                div_start;
  logic                out_load;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_product;
  logic                div_done;
  logic [RATE_W-1:0]   div_quot;
  logic                div_ovf;
  logic [TICK_W-1:0]   ram_rdata;
  logic [TICK_W-1:0]   old_ticks;
  logic                ring_full;

  assign cfg_ready = 1'b1;
  assign accept = in_valid & in_ready;
  assign ring_full = (filled_count == CNT_W'(WINDOW));
  // before the ring wraps the slot being replaced was never written
  assign old_ticks = ring_full ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        mul_start = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_frequency <= FREQ_RESET;
      update_period <= PERIOD_RESET;
      window_sum <= '0;
      write_slot <= '0;
      filled_count <= '0;
      frames_since_update <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TICK_FREQUENCY: tick_frequency <= cfg_data[FREQ_W-1:0];
          REG_UPDATE_PERIOD:  update_period <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (frames_since_update >= update_period) begin
          frames_since_update <= '0;
        end else begin
          frames_since_update <= frames_since_update + PERIOD_W'(1);
        end
      end
      if (state == ST_SUB) begin
        window_sum <= window_sum - SUM_W'(old_ticks);
        write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + SLOT_W'(1);
        if (!ring_full) begin
          filled_count <= filled_count + CNT_W'(1);
        end
      end
      if (state == ST_ADD) begin
        window_sum <= window_sum + SUM_W'(ticks);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ticks <= frame_ticks;
      flag <= (frames_since_update >= update_period);
    end
    if (out_load) begin
      rate_q8 <= ((window_sum == '0) || div_ovf) ? '1 : div_quot;
      rate_updated <= flag;
    end
  end

  swfrm_ram #(
    .WIDTH(TICK_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk(clk),
    .we(state == ST_SUB),
    .waddr(write_slot),
    .wdata(ticks),
    .re(accept),
    .raddr(write_slot),
    .rdata(ram_rdata)
  );

  swfrm_mul #(
    .A_W(CNT_W),
    .B_W(FREQ_W)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(filled_count),
    .b(tick_frequency),
    .done(mul_done),
    .product(mul_product)
  );

  swfrm_div #(
    .NUM_W(NUM_W),
    .DEN_W(SUM_W),
    .Q_W(RATE_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num({mul_product, {FRAC_W{1'b0}}}),
    .den(window_sum),
    .done(div_done),
    .quot(div_quot),
    .ovf(div_ovf)
  );

endmodule

[hdl/swfrm_checker.sv]
// port level checks for the sliding window frame rate meter
// uses swfrm_pkg; bound to the top level below
module swfrm_checker
  import swfrm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [TICK_W-1:0]     frame_ticks,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [RATE_W-1:0]     rate_q8,
  input logic                  rate_updated
);

  // a held result word keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rate_q8) && $stable(rate_updated))
    else $error("result word changed while stalled");

  // one word in flight: the input side closes right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a new result only appears as the block finishes a word
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready) && in_ready)
    else $error("result without a word in flight");

  // nothing left over from before reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind sliding_window_frame_rate_meter swfrm_checker u_swfrm_checker (.*);

[test/tb_sliding_window_frame_rate_meter.sv]
// testbench for the sliding window frame rate meter
// predicts rate_q8 and rate_updated for every accepted frame word and checks them in order
// depends on swfrm_pkg and sliding_window_frame_rate_meter
`timescale 1ns / 1ps

module tb_sliding_window_frame_rate_meter;
  import swfrm_pkg::*;

  localparam int RING_DEPTH = WINDOW_DEFAULT;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam logic [RATE_W-1:0] RATE_SAT = '1;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              flag;
  } rate_word_t;

  // running model of the meter plus the queue of rates still owed by the block
  class rate_scoreboard;
    logic [TICK_W-1:0]   ring [RING_DEPTH];
    logic [38:0]         window_total;
    int unsigned         slot;
    int unsigned         filled;
    logic [PERIOD_W-1:0] since_flag;
    logic [FREQ_W-1:0]   freq;
    logic [PERIOD_W-1:0] period;
    rate_word_t          owed_q[$];
    int unsigned         errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      window_total = '0;
      slot = 0;
      filled = 0;
      since_flag = '0;
      freq = FREQ_RESET;
      period = PERIOD_RESET;
      errors = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TICK_FREQUENCY) freq = data[FREQ_W-1:0];
      else if (idx == REG_UPDATE_PERIOD) period = data[PERIOD_W-1:0];
    endfunction

    function void note_frame(logic [TICK_W-1:0] ticks);
      logic [63:0] num;
      logic [63:0] quot;
      rate_word_t  w;
      window_total = window_total - ring[slot] + ticks;
      ring[slot] = ticks;
      if (filled < RING_DEPTH) filled++;
      slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
      num = (64'(filled) * 64'(freq)) << FRAC_W;
      if (window_total == 0) begin
        w.rate = RATE_SAT;
      end else begin
        quot = num / 64'(window_total);
        w.rate = (quot > 64'(RATE_SAT)) ? RATE_SAT : quot[RATE_W-1:0];
      end
      if (since_flag >= period) begin
        w.flag = 1'b1;
        since_flag = '0;
      end else begin
        w.flag = 1'b0;
        since_flag++;
      end
      owed_q.push_back(w);
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_rate(logic [RATE_W-1:0] rate, logic flag);
      rate_word_t w;
      if (owed_q.size() == 0) begin
        flag_error($sformatf("unexpected word rate_q8=%h rate_updated=%b", rate, flag));
        return;
      end
      w = owed_q.pop_front();
      if (rate !== w.rate)
        flag_error($sformatf("rate_q8 expected %h got %h", w.rate, rate));
      if (flag !== w.flag)
        flag_error($sformatf("rate_updated expected %b got %b", w.flag, flag));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [TICK_W-1:0]     frame_ticks;
  logic                  out_valid;
  logic                  out_ready;
  logic [RATE_W-1:0]     rate_q8;
  logic                  rate_updated;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  rate_scoreboard sb;

  sliding_window_frame_rate_meter #(
    .WINDOW(RING_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .frame_ticks(frame_ticks),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rate_q8(rate_q8),
    .rate_updated(rate_updated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result checked before the new frame is noted; the result always belongs to an older word
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_rate(rate_q8, rate_updated);
      if (cfg_valid && cfg_ready) sb.apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_frame(frame_ticks);
    end
  end

  // called at a falling edge; returns at a falling edge with in_valid still high
  task automatic send_frame(input logic [TICK_W-1:0] ticks);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_ticks <= ticks;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain(input int cycles);
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  // mostly plausible frame lengths for the current tick rate, plus full range noise, small values and zeros
  function automatic logic [TICK_W-1:0] random_ticks();
    int unsigned pick;
    logic [63:0] base;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      base = 64'(sb.freq) / 64'($urandom_range(24, 240));
      return TICK_W'(base + 64'($urandom_range(0, 32'(base >> 5))));
    end else if (pick < 85) begin
      return $urandom;
    end else if (pick < 95) begin
      return TICK_W'($urandom_range(0, 255));
    end
    return '0;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_frame(random_ticks());
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    frame_ticks = '0;
    out_ready = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 56;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings; all-zero window first, then tiny and huge frames, then typical ones
    send_frame('0);
    send_frame('0);
    send_frame(TICK_W'(1));
    send_frame('1);
    send_frame(TICK_W'(32'h8000_0000));
    send_frame(TICK_W'(16667));
    send_frame(TICK_W'(16667));
    send_frame(TICK_W'(33333));
    send_frame(TICK_W'(1000));
    send_frame(TICK_W'(5));
    drain(8);

    // zero frequency gives a zero rate, zero period flags every frame
    write_reg(REG_TICK_FREQUENCY, '0);
    write_reg(REG_UPDATE_PERIOD, '0);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_frame(TICK_W'(16667));
    send_frame('0);
    send_frame('1);
    send_frame(TICK_W'(32'h5555_5555));
    send_frame(TICK_W'(32'hAAAA_AAAA));
    drain(8);

    // largest frequency, period written with upper bits set to check masking
    write_reg(REG_TICK_FREQUENCY, '1);
    write_reg(REG_UPDATE_PERIOD, '1);
    send_frame(TICK_W'(1));
    send_frame('1);
    send_frame('1);
    send_frame(TICK_W'(32'h0000_FFFF));
    send_frame('0);
    send_frame(TICK_W'(32'hFFFF_0000));
    drain(8);

    write_reg(REG_TICK_FREQUENCY, $urandom_range(1000, 100_000_000));
    write_reg(REG_UPDATE_PERIOD, $urandom_range(1, 12));
    run_random(230);
    drain(8);

    send_idle_pct = 56;
    recv_idle_pct = 25;
    write_reg(REG_TICK_FREQUENCY, $urandom);
    write_reg(REG_UPDATE_PERIOD, {16'hFFFF, 16'($urandom_range(0, 3))});
    run_random(230);
    drain(8);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_TICK_FREQUENCY, $urandom_range(1, 40_000));
    write_reg(REG_UPDATE_PERIOD, $urandom_range(20, 70));
    run_random(230);
    drain(DRAIN_CYCLES);

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("tb_sliding_window_frame_rate_meter OK");
    end else begin
      $display("tb_sliding_window_frame_rate_meter NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_sliding_window_frame_rate_meter NOT OK");
    $finish;
  end

endmodule
